>>> rtl/core/sha1h_pkg.sv
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types and constants of the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

  // One classified input transaction as it travels from front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } cmd_t;

  localparam int CHAIN_WORDS = 5;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 80;
  localparam int DIGEST_BYTES = 20;

  // Initial chaining values h0 to h4.
  localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K_0 = 32'h5a827999;
  localparam logic [31:0] K_1 = 32'h6ed9eba1;
  localparam logic [31:0] K_2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_3 = 32'hca62c1d6;

  // First padding byte.
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // First position of the padding byte at which the length no longer fits
  // in the same block.
  localparam logic [5:0] PAD_SPLIT = 6'd56;

endpackage

>>> rtl/core/sha1h_front.sv
// ----------------------------------------------------------------------------
// sha1h_front
// Accepts input transactions, drops those that carry neither a byte nor an
// end mark, and holds the rest in a register until the queue takes them.
// ----------------------------------------------------------------------------
module sha1h_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_has_byte,
  input  logic               in_end_of_message,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output sha1h_pkg::cmd_t    cmd
);

  logic            hold_v_r, hold_v_nxt;
  sha1h_pkg::cmd_t cmd_r, cmd_nxt;
  logic            accept;
  logic            useful;

  // The holding register frees up in the same cycle that the queue takes it.
  assign in_ready  = !hold_v_r || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign useful    = in_has_byte || in_end_of_message;
  assign cmd_valid = hold_v_r;
  assign cmd       = cmd_r;

  // Next value of the holding register.
  always_comb begin
    hold_v_nxt = hold_v_r && !cmd_ready;
    cmd_nxt    = cmd_r;
    if (accept && useful) begin
      hold_v_nxt             = 1'b1;
      cmd_nxt.data_byte      = in_data_byte;
      cmd_nxt.has_byte       = in_has_byte;
      cmd_nxt.end_of_message = in_end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

>>> rtl/core/sha1h_fifo.sv
// ----------------------------------------------------------------------------
// sha1h_fifo
// Short command queue that decouples the front from the hashing back end.
// ----------------------------------------------------------------------------
module sha1h_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  sha1h_pkg::cmd_t wr_cmd,
  output logic            rd_valid,
  input  logic            rd_ready,
  output sha1h_pkg::cmd_t rd_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  sha1h_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push, pop;

  assign wr_ready = (count_r != CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = mem[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

>>> rtl/core/sha1h_back.sv
// ----------------------------------------------------------------------------
// sha1h_back
// Packs bytes into the block buffer, pads the final block, runs the round
// engine one round per cycle and streams the digest out through a register.
// ----------------------------------------------------------------------------
module sha1h_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  sha1h_pkg::cmd_t cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_digest_byte,
  output logic            out_digest_last
);

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_PAD1  = 5'b00010,
    ST_PAD2  = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  localparam logic [6:0] RND_ADD  = 7'(sha1h_pkg::ROUNDS);
  localparam logic [6:0] RND_G1   = 7'd20;
  localparam logic [6:0] RND_G2   = 7'd40;
  localparam logic [6:0] RND_G3   = 7'd60;
  localparam logic [4:0] OIDX_END = 5'(sha1h_pkg::DIGEST_BYTES - 1);
  localparam logic [5:0] FILL_END = 6'd63;

  // Sequencer and block buffer.
  state_t      state_r, state_nxt;
  logic [31:0] blk_r   [sha1h_pkg::BLOCK_WORDS];
  logic [31:0] blk_nxt [sha1h_pkg::BLOCK_WORDS];
  logic [5:0]  fill_r, fill_nxt;
  logic        full_r, full_nxt;
  logic        last_blk_r, last_blk_nxt;
  logic [60:0] msg_r, msg_nxt;
  logic [63:0] bit_len;

  // Round engine.
  logic [31:0] chain_r   [sha1h_pkg::CHAIN_WORDS];
  logic [31:0] chain_nxt [sha1h_pkg::CHAIN_WORDS];
  logic [31:0] win_r     [sha1h_pkg::BLOCK_WORDS];
  logic [31:0] win_nxt   [sha1h_pkg::BLOCK_WORDS];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic        busy_r, busy_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic        job_last_r, job_last_nxt;
  logic        start, fin_done;
  logic [31:0] f_val, k_val, t_val, w_new;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [4:0]  oidx_r, oidx_nxt;
  logic [31:0] sel_word;

  assign out_valid       = out_valid_r;
  assign out_digest_byte = out_byte_r;
  assign out_digest_last = out_last_r;

  assign bit_len  = {msg_r, 3'b000};
  assign start    = full_r && !busy_r;
  assign fin_done = busy_r && (rnd_r == RND_ADD) && job_last_r;
  assign sel_word = chain_r[oidx_r[4:2]];

  // Round function and constant for the current group of twenty rounds.
  always_comb begin
    priority if (rnd_r < RND_G1) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = sha1h_pkg::K_0;
    end else if (rnd_r < RND_G2) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1h_pkg::K_1;
    end else if (rnd_r < RND_G3) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = sha1h_pkg::K_2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1h_pkg::K_3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + win_r[0];
  assign w_new = {win_r[13][30:0] ^ win_r[8][30:0] ^ win_r[2][30:0] ^ win_r[0][30:0],
                  win_r[13][31] ^ win_r[8][31] ^ win_r[2][31] ^ win_r[0][31]};

  // Round engine: load a full block, run 80 rounds, then fold the working
  // words into the chaining words.
  always_comb begin
    win_nxt      = win_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    c_nxt        = c_r;
    d_nxt        = d_r;
    e_nxt        = e_r;
    busy_nxt     = busy_r;
    rnd_nxt      = rnd_r;
    job_last_nxt = job_last_r;
    if (start) begin
      win_nxt      = blk_r;
      a_nxt        = chain_r[0];
      b_nxt        = chain_r[1];
      c_nxt        = chain_r[2];
      d_nxt        = chain_r[3];
      e_nxt        = chain_r[4];
      busy_nxt     = 1'b1;
      rnd_nxt      = '0;
      job_last_nxt = last_blk_r;
    end else if (busy_r && (rnd_r != RND_ADD)) begin
      for (int i = 0; i < sha1h_pkg::BLOCK_WORDS - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[sha1h_pkg::BLOCK_WORDS-1] = w_new;
      a_nxt   = t_val;
      b_nxt   = a_r;
      c_nxt   = {b_r[1:0], b_r[31:2]};
      d_nxt   = c_r;
      e_nxt   = d_r;
      rnd_nxt = rnd_r + 1'b1;
    end else if (busy_r) begin
      busy_nxt = 1'b0;
    end
  end

  // Sequencer: byte packing, padding, length insertion and digest output.
  always_comb begin
    state_nxt     = state_r;
    blk_nxt       = blk_r;
    fill_nxt      = fill_r;
    full_nxt      = full_r;
    last_blk_nxt  = last_blk_r;
    msg_nxt       = msg_r;
    chain_nxt     = chain_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    oidx_nxt      = oidx_r;
    cmd_ready     = 1'b0;

    // The engine has taken the buffer: it starts over empty.
    if (start) begin
      for (int i = 0; i < sha1h_pkg::BLOCK_WORDS; i++) begin
        blk_nxt[i] = '0;
      end
      full_nxt     = 1'b0;
      last_blk_nxt = 1'b0;
    end

    // Fold the working words in at the end of a compression.
    if (busy_r && (rnd_r == RND_ADD)) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
      chain_nxt[4] = chain_r[4] + e_r;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (cmd_valid && !full_r) begin
          cmd_ready = 1'b1;
          if (cmd.has_byte) begin
            blk_nxt[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] = cmd.data_byte;
            msg_nxt  = msg_r + 1'b1;
            fill_nxt = fill_r + 1'b1;
            if (fill_r == FILL_END) begin
              full_nxt = 1'b1;
            end
          end
          if (cmd.end_of_message) begin
            state_nxt = ST_PAD1;
          end
        end
      end
      ST_PAD1: begin
        // The buffer is zeroed after each copy, so trailing zeros come free.
        if (!full_r) begin
          blk_nxt[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] = sha1h_pkg::PAD_BYTE;
          if (fill_r >= sha1h_pkg::PAD_SPLIT) begin
            full_nxt = 1'b1;
            fill_nxt = '0;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = ST_PAD2;
        end
      end
      ST_PAD2: begin
        if (!full_r) begin
          blk_nxt[14]  = bit_len[63:32];
          blk_nxt[15]  = bit_len[31:0];
          full_nxt     = 1'b1;
          last_blk_nxt = 1'b1;
          fill_nxt     = '0;
          state_nxt    = ST_FINAL;
        end
      end
      ST_FINAL: begin
        oidx_nxt = '0;
        if (fin_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = sel_word[{~oidx_r[1:0], 3'b000} +: 8];
          out_last_nxt  = (oidx_r == OIDX_END);
          oidx_nxt      = oidx_r + 1'b1;
          if (oidx_r == OIDX_END) begin
            // Digest handed over: reinitialise for the next message.
            chain_nxt = sha1h_pkg::H_INIT;
            msg_nxt   = '0;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control state and the architectural state of the hash.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      full_r      <= 1'b0;
      last_blk_r  <= 1'b0;
      msg_r       <= '0;
      busy_r      <= 1'b0;
      rnd_r       <= '0;
      job_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
      oidx_r      <= '0;
      chain_r     <= sha1h_pkg::H_INIT;
      for (int i = 0; i < sha1h_pkg::BLOCK_WORDS; i++) begin
        blk_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      full_r      <= full_nxt;
      last_blk_r  <= last_blk_nxt;
      msg_r       <= msg_nxt;
      busy_r      <= busy_nxt;
      rnd_r       <= rnd_nxt;
      job_last_r  <= job_last_nxt;
      out_valid_r <= out_valid_nxt;
      oidx_r      <= oidx_nxt;
      chain_r     <= chain_nxt;
      blk_r       <= blk_nxt;
    end
  end

  // Working words, schedule window and output payload.
  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> rtl/core/sha1_byte_stream_hasher_core.sv
// Path: a byte passes through the front's holding register and the queue and is
//   packed in the cycle it leaves the queue; each full block then passes the
//   round engine in order: a load, 80 rounds and a fold.
// Block rate: bounded by the single round unit;
//   the next block loads while the current one compresses.
// End of message: padding in ST_PAD1 and ST_PAD2, one or two compressions, 20 digest bytes.
// Reset: synchronous, active low; chaining words return to their initial values.
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_core
// SHA-1 over a byte stream: front classifier, command queue and hashing back.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_digest_byte,
  output logic       out_digest_last
);

  sha1h_pkg::cmd_t front_cmd, back_cmd;
  logic            front_valid, front_ready;
  logic            back_valid, back_ready;

  // Front: accepts and classifies input transactions.
  sha1h_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .cmd_valid         (front_valid),
    .cmd_ready         (front_ready),
    .cmd               (front_cmd)
  );

  // Queue between the two halves.
  sha1h_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_cmd   (back_cmd)
  );

  // Back: packing, padding, compression and digest output.
  sha1h_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (back_valid),
    .cmd_ready       (back_ready),
    .cmd             (back_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_byte (out_digest_byte),
    .out_digest_last (out_digest_last)
  );

endmodule

>>> rtl/core/sha1h_checker.sv
// ----------------------------------------------------------------------------
// sha1h_checker
// Port-level checks of the hasher's digest stream, bound to the top level.
// ----------------------------------------------------------------------------
module sha1h_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_digest_byte,
  input logic       out_digest_last
);

  localparam logic [4:0] POS_LAST = 5'(sha1h_pkg::DIGEST_BYTES - 1);

  logic [4:0] pos_r;
  logic       out_fire;

  assign out_fire = out_valid && out_ready;

  // Position of the next digest byte within its digest.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (out_fire) begin
      pos_r <= out_digest_last ? '0 : pos_r + 1'b1;
    end
  end

  // No digest byte is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("digest offered straight after reset");

  // A stalled digest byte holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_byte)
                                && $stable(out_digest_last))
    else $error("stalled digest transaction changed");

  // The last mark sits on exactly the twentieth byte of each digest.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digest_last == (pos_r == POS_LAST)))
    else $error("digest last mark out of place");

  // A new digest cannot follow straight on from the end of the previous one.
  a_digest_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_digest_last |=> !out_valid)
    else $error("digest bytes continued past the last one");

endmodule

bind sha1_byte_stream_hasher_core sha1h_checker u_sha1h_checker (.*);
